// ===== rtl/whss_pkg.sv =====
// Shared types, register codes and reset values for the water hysteresis
// servo slew unit. No dependencies.
package whss_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_WET_THRESHOLD    = 3'd0,
    REG_DRY_THRESHOLD    = 3'd1,
    REG_SMOOTHING_GAIN   = 3'd2,
    REG_WET_TARGET       = 3'd3,
    REG_DRY_TARGET       = 3'd4,
    REG_STEP_INTERVAL_MS = 3'd5,
    REG_LIGHT_THRESHOLD  = 3'd6
  } reg_idx_t;

  // Command codes carried in the func field
  localparam logic [1:0] FUNC_NONE   = 2'd0;
  localparam logic [1:0] FUNC_SERVO1 = 2'd1;
  localparam logic [1:0] FUNC_SERVO2 = 2'd2;

  localparam logic [9:0]  RST_WET_THRESHOLD    = 10'd780;
  localparam logic [9:0]  RST_DRY_THRESHOLD    = 10'd820;
  localparam logic [8:0]  RST_SMOOTHING_GAIN   = 9'd51;
  localparam logic [7:0]  RST_WET_TARGET       = 8'd45;
  localparam logic [7:0]  RST_DRY_TARGET       = 8'd0;
  localparam logic [15:0] RST_STEP_INTERVAL_MS = 16'd15;
  localparam logic [9:0]  RST_LIGHT_THRESHOLD  = 10'd500;

  localparam logic [7:0] ANGLE_MAX = 8'd180;
  localparam logic [8:0] GAIN_MAX  = 9'd256;

  typedef struct packed {
    logic [9:0]  wet_threshold;
    logic [9:0]  dry_threshold;
    logic [8:0]  smoothing_gain;
    logic [7:0]  wet_target;
    logic [7:0]  dry_target;
    logic [15:0] step_interval_ms;
    logic [9:0]  light_threshold;
  } cfg_t;

  function automatic logic [7:0] clamp_angle(input logic [7:0] a);
    clamp_angle = (a > ANGLE_MAX) ? ANGLE_MAX : a;
  endfunction

  function automatic logic [7:0] move_toward(input logic [7:0] pos, input logic [7:0] goal);
    if (pos < goal) begin
      move_toward = pos + 8'd1;
    end else if (pos > goal) begin
      move_toward = pos - 8'd1;
    end else begin
      move_toward = pos;
    end
  endfunction

endpackage

// ===== rtl/whss_filter.sv =====
// EWMA water filter in Q10.8 with wet/dry hysteresis state.
// Depends on whss_pkg for cfg_t.
module whss_filter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              update,
  input  whss_pkg::cfg_t    cfg,
  input  logic [9:0]        water_sample,
  output logic [17:0]       filt_nxt,
  output logic              wet_nxt
);

  logic [17:0] filt_r;
  logic        seeded_r;
  logic        wet_r;

  logic [8:0]         gain;
  logic [17:0]        sample_q;
  logic signed [18:0] diff;
  logic signed [28:0] prod;
  logic signed [28:0] acc;
  logic               turn_wet;

  assign gain     = (cfg.smoothing_gain > whss_pkg::GAIN_MAX) ? whss_pkg::GAIN_MAX
                                                              : cfg.smoothing_gain;
  assign sample_q = {water_sample, 8'd0};

  // g*s + (256-g)*F == 256*F + g*(s-F), one multiplier
  assign diff = $signed({1'b0, sample_q}) - $signed({1'b0, filt_r});
  assign prod = $signed({1'b0, gain}) * diff;
  assign acc  = $signed({3'd0, filt_r, 8'd0}) + prod + 29'sd128;

  assign filt_nxt = seeded_r ? acc[25:8] : sample_q;

  assign turn_wet = wet_r | (filt_nxt < {cfg.wet_threshold, 8'd0});
  assign wet_nxt  = turn_wet & ~(filt_nxt > {cfg.dry_threshold, 8'd0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r   <= '0;
      seeded_r <= 1'b0;
      wet_r    <= 1'b0;
    end else if (update) begin
      filt_r   <= filt_nxt;
      seeded_r <= 1'b1;
      wet_r    <= wet_nxt;
    end
  end

endmodule

// ===== rtl/whss_servo.sv =====
// Slew-limited position tracking for both servos, one degree per interval.
// Depends on whss_pkg for cfg_t, command codes and angle helpers.
module whss_servo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              update,
  input  whss_pkg::cfg_t    cfg,
  input  logic              wet,
  input  logic [1:0]        func,
  input  logic signed [10:0] command_angle,
  input  logic [31:0]       now_ms,
  output logic [7:0]        servo1_nxt,
  output logic [7:0]        servo2_nxt
);

  logic [7:0]  servo1_r;
  logic [7:0]  servo2_r;
  logic [7:0]  goal2_r;
  logic [31:0] last_step_r;

  logic        angle_ok;
  logic [7:0]  cmd_angle;
  logic [7:0]  target1;
  logic [7:0]  goal2_nxt;
  logic [31:0] elapsed;
  logic        step;

  assign angle_ok  = ~command_angle[10] && (command_angle[9:0] <= {2'd0, whss_pkg::ANGLE_MAX});
  assign cmd_angle = command_angle[7:0];

  always_comb begin
    target1 = wet ? whss_pkg::clamp_angle(cfg.wet_target)
                  : whss_pkg::clamp_angle(cfg.dry_target);
    if (angle_ok && func == whss_pkg::FUNC_SERVO1) begin
      target1 = cmd_angle;
    end
  end

  assign goal2_nxt = (angle_ok && func == whss_pkg::FUNC_SERVO2) ? cmd_angle : goal2_r;

  assign elapsed = now_ms - last_step_r;
  assign step    = elapsed >= {16'd0, cfg.step_interval_ms};

  assign servo1_nxt = step ? whss_pkg::move_toward(servo1_r, target1)   : servo1_r;
  assign servo2_nxt = step ? whss_pkg::move_toward(servo2_r, goal2_nxt) : servo2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo1_r    <= '0;
      servo2_r    <= '0;
      goal2_r     <= '0;
      last_step_r <= '0;
    end else if (update) begin
      servo1_r <= servo1_nxt;
      servo2_r <= servo2_nxt;
      goal2_r  <= goal2_nxt;
      if (step) begin
        last_step_r <= now_ms;
      end
    end
  end

endmodule

// ===== rtl/water_hysteresis_servo_slew_unit.sv =====
// Top level of the water hysteresis servo slew unit: config registers,
// request and result registers. Depends on whss_pkg, whss_filter, whss_servo.
//
// Usage:
//   Input channel in_valid/in_stall carries one control-loop pass per request:
//   light and water samples, an optional servo command and the ms timestamp.
//   Result channel out_valid/out_stall returns LED, wet flag, filtered level
//   (Q10.8) and both servo positions, one result per request, in order.
//   Registers are to be written through cfg_we/cfg_index/cfg_wdata while idle (the
//   block does not enforce it); writes to an index past the light threshold are dropped.
// Timing:
//   A taken request waits in the request register until the result register
//   is free, is then processed into it and is visible on the out_ ports from
//   there. One request per cycle is sustained while out_stall is low; the
//   filter/hysteresis/servo update between the two registers is combinational.
// Reset and stall:
//   rst_n low clears all loop state, the filter seed flag and both valids,
//   and loads the register defaults. While out_stall holds a full result
//   register, the request register holds and in_stall rises once it is full.
module water_hysteresis_servo_slew_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [9:0]                      in_light_sample,
  input  logic [9:0]                      in_water_sample,
  input  logic [1:0]                      in_func,
  input  logic signed [10:0]              in_command_angle,
  input  logic [31:0]                     in_now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_led_on,
  output logic                            out_is_wet,
  output logic [17:0]                     out_filtered_level,
  output logic [7:0]                      out_servo1_angle,
  output logic [7:0]                      out_servo2_angle,
  input  logic                            cfg_we,
  input  logic [whss_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [whss_pkg::CfgDataW-1:0]   cfg_wdata
);

  whss_pkg::cfg_t cfg_r;

  logic              req_valid_r;
  logic [9:0]        light_r;
  logic [9:0]        water_r;
  logic [1:0]        func_r;
  logic signed [10:0] cmd_r;
  logic [31:0]       now_r;

  logic              res_valid_r;
  logic              led_r;
  logic              wet_r;
  logic [17:0]       level_r;
  logic [7:0]        servo1_r;
  logic [7:0]        servo2_r;

  logic        res_free;
  logic        advance;
  logic        in_take;
  logic [17:0] filt_nxt;
  logic        wet_nxt;
  logic [7:0]  servo1_nxt;
  logic [7:0]  servo2_nxt;

  assign res_free = ~res_valid_r | ~out_stall;
  assign advance  = req_valid_r & res_free;
  assign in_stall = req_valid_r & ~res_free;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wet_threshold    <= whss_pkg::RST_WET_THRESHOLD;
      cfg_r.dry_threshold    <= whss_pkg::RST_DRY_THRESHOLD;
      cfg_r.smoothing_gain   <= whss_pkg::RST_SMOOTHING_GAIN;
      cfg_r.wet_target       <= whss_pkg::RST_WET_TARGET;
      cfg_r.dry_target       <= whss_pkg::RST_DRY_TARGET;
      cfg_r.step_interval_ms <= whss_pkg::RST_STEP_INTERVAL_MS;
      cfg_r.light_threshold  <= whss_pkg::RST_LIGHT_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        whss_pkg::REG_WET_THRESHOLD:    cfg_r.wet_threshold    <= cfg_wdata[9:0];
        whss_pkg::REG_DRY_THRESHOLD:    cfg_r.dry_threshold    <= cfg_wdata[9:0];
        whss_pkg::REG_SMOOTHING_GAIN:   cfg_r.smoothing_gain   <= cfg_wdata[8:0];
        whss_pkg::REG_WET_TARGET:       cfg_r.wet_target       <= cfg_wdata[7:0];
        whss_pkg::REG_DRY_TARGET:       cfg_r.dry_target       <= cfg_wdata[7:0];
        whss_pkg::REG_STEP_INTERVAL_MS: cfg_r.step_interval_ms <= cfg_wdata[15:0];
        whss_pkg::REG_LIGHT_THRESHOLD:  cfg_r.light_threshold  <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_take) begin
      req_valid_r <= 1'b1;
    end else if (advance) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      light_r <= in_light_sample;
      water_r <= in_water_sample;
      func_r  <= in_func;
      cmd_r   <= in_command_angle;
      now_r   <= in_now_ms;
    end
  end

  whss_filter u_filter (
    .clk          (clk),
    .rst_n        (rst_n),
    .update       (advance),
    .cfg          (cfg_r),
    .water_sample (water_r),
    .filt_nxt     (filt_nxt),
    .wet_nxt      (wet_nxt)
  );

  whss_servo u_servo (
    .clk           (clk),
    .rst_n         (rst_n),
    .update        (advance),
    .cfg           (cfg_r),
    .wet           (wet_nxt),
    .func          (func_r),
    .command_angle (cmd_r),
    .now_ms        (now_r),
    .servo1_nxt    (servo1_nxt),
    .servo2_nxt    (servo2_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (~out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_r    <= light_r > cfg_r.light_threshold;
      wet_r    <= wet_nxt;
      level_r  <= filt_nxt;
      servo1_r <= servo1_nxt;
      servo2_r <= servo2_nxt;
    end
  end

  assign out_valid          = res_valid_r;
  assign out_led_on         = led_r;
  assign out_is_wet         = wet_r;
  assign out_filtered_level = level_r;
  assign out_servo1_angle   = servo1_r;
  assign out_servo2_angle   = servo2_r;

endmodule

// ===== tb/water_hysteresis_servo_slew_unit_test.sv =====
// Self-checking testbench for water_hysteresis_servo_slew_unit: a queue-fed driver, a clocked
// monitor and an in-house model of the filter, hysteresis and servo slew logic.
// Depends on whss_pkg and the unit's RTL.
module water_hysteresis_servo_slew_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]                   FUNC_RESERVED = 2'd3;
  localparam logic [whss_pkg::CfgIdxW-1:0] REG_SPARE     = 3'd7;
  localparam int                           CYCLE_LIMIT   = 100000;

  typedef struct packed {
    logic [9:0]         light;
    logic [9:0]         water;
    logic [1:0]         func;
    logic signed [10:0] angle;
    logic [31:0]        now;
  } loop_pass_t;

  typedef struct packed {
    logic        led;
    logic        wet;
    logic [17:0] level;
    logic [7:0]  servo1;
    logic [7:0]  servo2;
  } loop_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [9:0] in_light_sample = '0;
  logic [9:0] in_water_sample = '0;
  logic [1:0] in_func = whss_pkg::FUNC_NONE;
  logic signed [10:0] in_command_angle = '0;
  logic [31:0] in_now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_led_on;
  logic out_is_wet;
  logic [17:0] out_filtered_level;
  logic [7:0] out_servo1_angle;
  logic [7:0] out_servo2_angle;
  logic cfg_we = 1'b0;
  logic [whss_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [whss_pkg::CfgDataW-1:0] cfg_wdata = '0;

  water_hysteresis_servo_slew_unit uut (.*);

  always #5 clk = ~clk;

  loop_pass_t   pending_passes[$];
  loop_result_t expected_results[$];
  logic req_taken = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   fail_count = 0;
  int   cycle_count = 0;

  // Model copy of the registers and loop state
  logic [9:0]  wet_thr_q, dry_thr_q, light_thr_q;
  logic [8:0]  gain_q;
  logic [7:0]  wet_ang_q, dry_ang_q;
  logic [15:0] step_q;
  logic [17:0] level_q;
  logic        seeded_q, wet_q;
  logic [7:0]  s1_pos_q, s2_pos_q, s2_goal_q;
  logic [31:0] last_step_q;

  // Stimulus walk state
  logic [31:0] time_ms = '0;
  logic [9:0]  water_walk = 10'd512;

  task automatic reset_model();
    wet_thr_q   = whss_pkg::RST_WET_THRESHOLD;
    dry_thr_q   = whss_pkg::RST_DRY_THRESHOLD;
    gain_q      = whss_pkg::RST_SMOOTHING_GAIN;
    wet_ang_q   = whss_pkg::RST_WET_TARGET;
    dry_ang_q   = whss_pkg::RST_DRY_TARGET;
    step_q      = whss_pkg::RST_STEP_INTERVAL_MS;
    light_thr_q = whss_pkg::RST_LIGHT_THRESHOLD;
    level_q     = '0;
    seeded_q    = 1'b0;
    wet_q       = 1'b0;
    s1_pos_q    = '0;
    s2_pos_q    = '0;
    s2_goal_q   = '0;
    last_step_q = '0;
  endtask

  function automatic logic [7:0] nudge(input logic [7:0] pos, input logic [7:0] goal);
    if (pos < goal) return pos + 8'd1;
    if (pos > goal) return pos - 8'd1;
    return pos;
  endfunction

  task automatic advance_loop(input loop_pass_t p, output loop_result_t r);
    logic [8:0]  g;
    logic [31:0] acc;
    logic [31:0] elapsed;
    logic [7:0]  aim;
    logic [7:0]  base;
    if (!seeded_q) begin
      level_q  = {p.water, 8'b0};
      seeded_q = 1'b1;
    end else begin
      g = (gain_q > whss_pkg::GAIN_MAX) ? whss_pkg::GAIN_MAX : gain_q;
      acc = 32'(g) * 32'({p.water, 8'b0}) + (32'd256 - 32'(g)) * 32'(level_q) + 32'd128;
      level_q = acc[25:8];
    end
    if (!wet_q && level_q < {wet_thr_q, 8'b0}) wet_q = 1'b1;
    if (wet_q && level_q > {dry_thr_q, 8'b0}) wet_q = 1'b0;
    base = wet_q ? wet_ang_q : dry_ang_q;
    aim = (base > whss_pkg::ANGLE_MAX) ? whss_pkg::ANGLE_MAX : base;
    // out-of-range or negative commands are dropped
    if (!p.angle[10] && p.angle[9:0] <= 10'd180) begin
      if (p.func == whss_pkg::FUNC_SERVO1) begin
        aim = p.angle[7:0];
      end else if (p.func == whss_pkg::FUNC_SERVO2) begin
        s2_goal_q = p.angle[7:0];
      end
    end
    elapsed = p.now - last_step_q;
    if (elapsed >= {16'b0, step_q}) begin
      last_step_q = p.now;
      s1_pos_q = nudge(s1_pos_q, aim);
      s2_pos_q = nudge(s2_pos_q, s2_goal_q);
    end
    r.led    = p.light > light_thr_q;
    r.wet    = wet_q;
    r.level  = level_q;
    r.servo1 = s1_pos_q;
    r.servo2 = s2_pos_q;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Driver: present the next request at the falling edge once the last one is taken
  always @(negedge clk) begin : feed
    loop_pass_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_passes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_passes.pop_front();
        in_valid         <= 1'b1;
        in_light_sample  <= nxt.light;
        in_water_sample  <= nxt.water;
        in_func          <= nxt.func;
        in_command_angle <= nxt.angle;
        in_now_ms        <= nxt.now;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Monitor: track register writes, predict accepted requests, check results
  always @(posedge clk) begin : observe
    loop_pass_t   seen;
    loop_result_t want;
    loop_result_t pred;
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && !in_stall;
      if (cfg_we) begin
        case (cfg_index)
          whss_pkg::REG_WET_THRESHOLD:    wet_thr_q   = cfg_wdata[9:0];
          whss_pkg::REG_DRY_THRESHOLD:    dry_thr_q   = cfg_wdata[9:0];
          whss_pkg::REG_SMOOTHING_GAIN:   gain_q      = cfg_wdata[8:0];
          whss_pkg::REG_WET_TARGET:       wet_ang_q   = cfg_wdata[7:0];
          whss_pkg::REG_DRY_TARGET:       dry_ang_q   = cfg_wdata[7:0];
          whss_pkg::REG_STEP_INTERVAL_MS: step_q      = cfg_wdata;
          whss_pkg::REG_LIGHT_THRESHOLD:  light_thr_q = cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("led_on", want.led, out_led_on);
          check_field("is_wet", want.wet, out_is_wet);
          check_field("filtered_level", want.level, out_filtered_level);
          check_field("servo1_angle", want.servo1, out_servo1_angle);
          check_field("servo2_angle", want.servo2, out_servo2_angle);
        end
      end
      if (in_valid && !in_stall) begin
        seen.light = in_light_sample;
        seen.water = in_water_sample;
        seen.func  = in_func;
        seen.angle = in_command_angle;
        seen.now   = in_now_ms;
        advance_loop(seen, pred);
        expected_results.push_back(pred);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [whss_pkg::CfgIdxW-1:0] idx,
                           input logic [whss_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_pass(input logic [9:0] light, input logic [9:0] water,
                          input logic [1:0] func, input logic signed [10:0] angle,
                          input logic [31:0] now);
    loop_pass_t p;
    p.light = light;
    p.water = water;
    p.func  = func;
    p.angle = angle;
    p.now   = now;
    pending_passes.push_back(p);
  endtask

  // Wait until every request is out and checked
  task automatic settle();
    while (pending_passes.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic randomize_settings();
    int center;
    int band;
    if ($urandom_range(0, 4) == 0) begin
      write_reg(whss_pkg::REG_WET_THRESHOLD, 16'($urandom_range(0, 1023)));
      write_reg(whss_pkg::REG_DRY_THRESHOLD, 16'($urandom_range(0, 1023)));
    end else begin
      center = $urandom_range(100, 900);
      band   = $urandom_range(0, 100);
      write_reg(whss_pkg::REG_WET_THRESHOLD, 16'(center - band));
      write_reg(whss_pkg::REG_DRY_THRESHOLD, 16'(center + band));
    end
    write_reg(whss_pkg::REG_SMOOTHING_GAIN,
              ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 511))
                                          : 16'($urandom_range(1, 128)));
    write_reg(whss_pkg::REG_WET_TARGET,
              ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255))
                                          : 16'($urandom_range(0, 180)));
    write_reg(whss_pkg::REG_DRY_TARGET,
              ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255))
                                          : 16'($urandom_range(0, 180)));
    case ($urandom_range(0, 5))
      0:       write_reg(whss_pkg::REG_STEP_INTERVAL_MS, 16'd0);
      1:       write_reg(whss_pkg::REG_STEP_INTERVAL_MS, 16'($urandom()));
      default: write_reg(whss_pkg::REG_STEP_INTERVAL_MS, 16'($urandom_range(1, 40)));
    endcase
    write_reg(whss_pkg::REG_LIGHT_THRESHOLD, 16'($urandom_range(0, 1023)));
    write_reg(REG_SPARE, 16'($urandom()));
  endtask

  task automatic queue_random_passes(input int count);
    loop_pass_t p;
    int w;
    int pick;
    for (int i = 0; i < count; i++) begin
      p.light = 10'($urandom_range(0, 1023));
      // random walk on the water level so the hysteresis band gets crossed
      if ($urandom_range(0, 9) == 0) begin
        water_walk = 10'($urandom_range(0, 1023));
      end else begin
        w = int'(water_walk) + int'($urandom_range(0, 120)) - 60;
        water_walk = (w < 0) ? 10'd0 : (w > 1023) ? 10'd1023 : 10'(w);
      end
      p.water = water_walk;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        p.func  = whss_pkg::FUNC_NONE;
        p.angle = 11'($urandom_range(0, 180));
      end else if (pick < 62) begin
        p.func  = whss_pkg::FUNC_SERVO1;
        p.angle = 11'($urandom_range(0, 180));
      end else if (pick < 90) begin
        p.func  = whss_pkg::FUNC_SERVO2;
        p.angle = 11'($urandom_range(0, 180));
      end else begin
        p.func  = 2'($urandom_range(0, 3));
        p.angle = 11'($urandom());
      end
      pick = $urandom_range(0, 49);
      if (pick == 0) begin
        time_ms = $urandom();
      end else if (pick == 1) begin
        time_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
      end else if (pick < 14) begin
        time_ms = time_ms + step_q;
      end else begin
        time_ms = time_ms + $urandom_range(0, 24);
      end
      p.now = time_ms;
      pending_passes.push_back(p);
    end
  endtask

  initial begin
    reset_model();
    send_idle_pct = 36;
    recv_idle_pct = 77;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Defaults: seed, LED edge, command range edges, reserved func
    add_pass(10'd1023, 10'd1023, whss_pkg::FUNC_NONE,   11'sd0,     32'd0);
    add_pass(10'd0,    10'd0,    whss_pkg::FUNC_SERVO1, 11'sd180,   32'd15);
    add_pass(10'd500,  10'd0,    whss_pkg::FUNC_SERVO2, 11'sd180,   32'd30);
    add_pass(10'd501,  10'd512,  FUNC_RESERVED,         11'sd90,    32'd45);
    add_pass(10'd1023, 10'd1023, whss_pkg::FUNC_SERVO1, -11'sd1,    32'd60);
    add_pass(10'd0,    10'd1023, whss_pkg::FUNC_SERVO1, 11'sd181,   32'd75);
    add_pass(10'd0,    10'd0,    whss_pkg::FUNC_SERVO2, -11'sd1024, 32'd80);
    add_pass(10'd0,    10'd0,    whss_pkg::FUNC_SERVO2, 11'sd1023,  32'd95);
    settle();

    // Overlapping thresholds, saturated gain and angles, step every request
    write_reg(whss_pkg::REG_WET_THRESHOLD, 16'd1023);
    write_reg(whss_pkg::REG_DRY_THRESHOLD, 16'd0);
    write_reg(whss_pkg::REG_SMOOTHING_GAIN, 16'd300);
    write_reg(whss_pkg::REG_WET_TARGET, 16'd200);
    write_reg(whss_pkg::REG_DRY_TARGET, 16'd255);
    write_reg(whss_pkg::REG_STEP_INTERVAL_MS, 16'd0);
    write_reg(whss_pkg::REG_LIGHT_THRESHOLD, 16'd0);
    write_reg(REG_SPARE, 16'hFFFF);
    add_pass(10'd0,    10'd1023, whss_pkg::FUNC_NONE,   11'sd0,   32'hFFFF_FFF0);
    add_pass(10'd1,    10'd0,    whss_pkg::FUNC_NONE,   11'sd0,   32'hFFFF_FFFF);
    add_pass(10'd1023, 10'd1023, whss_pkg::FUNC_SERVO1, 11'sd180, 32'd0);
    add_pass(10'd0,    10'd0,    whss_pkg::FUNC_SERVO2, 11'sd7,   32'd3);
    add_pass(10'd1023, 10'd1023, whss_pkg::FUNC_NONE,   11'sd0,   32'd3);
    add_pass(10'd0,    10'd0,    whss_pkg::FUNC_NONE,   11'sd0,   32'd3);
    settle();

    // Frozen filter, widest thresholds, longest interval across the wrap
    write_reg(whss_pkg::REG_WET_THRESHOLD, 16'd0);
    write_reg(whss_pkg::REG_DRY_THRESHOLD, 16'd1023);
    write_reg(whss_pkg::REG_SMOOTHING_GAIN, 16'd0);
    write_reg(whss_pkg::REG_WET_TARGET, 16'd180);
    write_reg(whss_pkg::REG_DRY_TARGET, 16'd90);
    write_reg(whss_pkg::REG_STEP_INTERVAL_MS, 16'hFFFF);
    write_reg(whss_pkg::REG_LIGHT_THRESHOLD, 16'd1023);
    add_pass(10'd1023, 10'd1023, whss_pkg::FUNC_SERVO2, 11'sd0,   32'd65537);
    add_pass(10'd1022, 10'd0,    whss_pkg::FUNC_NONE,   11'sd0,   32'd65538);
    add_pass(10'd1023, 10'd0,    whss_pkg::FUNC_SERVO1, 11'sd100, 32'hFFFF_0000);
    add_pass(10'd0,    10'd1023, whss_pkg::FUNC_NONE,   11'sd0,   32'h0000_FFFF);
    add_pass(10'd0,    10'd512,  whss_pkg::FUNC_NONE,   11'sd0,   32'h0001_0000);
    settle();

    time_ms = 32'h0002_0000;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 77 : 0;
      recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 36 : 0;
      for (int half = 0; half < 2; half++) begin
        settle();
        randomize_settings();
        queue_random_passes(67);
      end
    end
    settle();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/whss_pkg.sv
rtl/whss_filter.sv
rtl/whss_servo.sv
rtl/water_hysteresis_servo_slew_unit.sv
tb/water_hysteresis_servo_slew_unit_test.sv
